>>> design/wfht_pkg.sv
// shared types and constants for the word frequency hash table
package wfht_pkg;

	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_PERIOD  = 8'h2E;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;
	localparam logic [31:0] HASH_INIT   = 32'd5381;
	localparam logic [31:0] HASH_KEEP   = 32'h7FFF_FFFF;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
	localparam logic [1:0] STATUS_POOL_FULL = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic accept_char;   // fold a word byte into the word buffer and hash
		logic clear_word;    // restart word and hash
		logic head_rd;       // read bucket head
		logic head_wr;       // write bucket head with new node
		logic node_rd;       // read node meta at current pointer
		logic cmp_start;     // reset compare index
		logic text_rd;       // read text byte at current pointer and index
		logic cmp_step;      // compare the returned byte, advance index
		logic follow_next;   // pointer <= node next
		logic take_head;     // pointer <= bucket head
		logic ins_text_wr;   // write one word byte to the new node
		logic ins_meta_wr;   // write meta of the new node
		logic upd_count;     // write incremented count
		logic alloc;         // nodes_used++
		logic clr_wr;        // clearing pass write
	} wfht_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_sep;
		logic word_empty;
		logic ptr_valid;     // pointer below nodes_used
		logic len_match;     // node length equals word length
		logic byte_match;
		logic cmp_last;      // compare index reached word length
		logic ins_last;      // insertion index reached word length
		logic pool_full;
		logic clr_last;
	} wfht_status_t;

endpackage

>>> design/wfht_stream_if.sv
// valid/ready stream interface with a generic payload
interface wfht_stream_if #(
	parameter int WIDTH = 8
) ();
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> design/wfht_ram.sv
// generic single port write, single port read ram with registered read
module wfht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

>>> design/wfht_datapath.sv
// word buffer, hash, bucket heads and node pool storage
module wfht_datapath #(
	parameter int BUCKETS      = 256,
	parameter int MAX_WORD_LEN = 19,
	parameter int POOL_NODES   = 1024,
	parameter int COUNT_WIDTH  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [7:0]              char_code,
	input  wfht_pkg::wfht_cmd_t     cmd,
	output wfht_pkg::wfht_status_t  stat,
	output logic [7:0]              res_bucket,
	output logic [15:0]             res_count,
	output logic                    res_truncated
);
	localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int NW  = $clog2(POOL_NODES);
	localparam int PW  = NW + 1;
	localparam int LW  = $clog2(MAX_WORD_LEN + 1);
	localparam int IW  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
	localparam int TD  = POOL_NODES * MAX_WORD_LEN;
	localparam int TW  = $clog2(TD);
	localparam logic [PW-1:0] NIL = PW'(POOL_NODES);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	logic [7:0]       word_q [MAX_WORD_LEN];
	logic [LW-1:0]    len_q;
	logic [31:0]      hash_q;
	logic             trunc_q;
	logic [PW-1:0]    used_q;
	logic [PW-1:0]    ptr_q;
	logic [LW-1:0]    idx_q;
	logic [BW-1:0]    clr_q;
	logic [7:0]       folded;
	logic [BW-1:0]    bkt;
	logic [31:0]      hash_masked;

	assign folded = (char_code >= wfht_pkg::CHAR_UPPER_A && char_code <= wfht_pkg::CHAR_UPPER_Z)
		? char_code + wfht_pkg::CASE_OFFSET : char_code;
	assign hash_masked = hash_q & wfht_pkg::HASH_KEEP;
	assign bkt = BW'(hash_masked % BUCKETS);

	always_ff @(posedge clk) begin
		if (cmd.accept_char && len_q < LW'(MAX_WORD_LEN)) begin
			word_q[len_q[IW-1:0]] <= folded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			hash_q  <= wfht_pkg::HASH_INIT;
			trunc_q <= 1'b0;
			used_q  <= '0;
			clr_q   <= '0;
		end else begin
			if (cmd.clear_word) begin
				len_q   <= '0;
				hash_q  <= wfht_pkg::HASH_INIT;
				trunc_q <= 1'b0;
			end else if (cmd.accept_char) begin
				if (len_q < LW'(MAX_WORD_LEN)) begin
					len_q  <= len_q + 1'b1;
					hash_q <= (hash_q << 5) + hash_q + {24'd0, folded};
				end else begin
					trunc_q <= 1'b1;
				end
			end
			if (cmd.alloc) begin
				used_q <= used_q + 1'b1;
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// bucket heads
	logic [PW-1:0] head_rd;
	wfht_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_heads (
		.clk(clk),
		.wr_en(cmd.head_wr || cmd.clr_wr),
		.wr_addr(cmd.clr_wr ? clr_q : bkt),
		.wr_data(cmd.clr_wr ? NIL : used_q),
		.rd_en(cmd.head_rd),
		.rd_addr(bkt),
		.rd_data(head_rd)
	);

	// node metadata: length, next, count
	localparam int MW = LW + PW + COUNT_WIDTH;
	logic [MW-1:0] meta_rd;
	logic [MW-1:0] meta_wd;
	logic [LW-1:0] n_len;
	logic [PW-1:0] n_next;
	logic [COUNT_WIDTH-1:0] n_cnt, n_cnt_inc;
	assign n_len  = meta_rd[MW-1 -: LW];
	assign n_next = meta_rd[PW+COUNT_WIDTH-1 -: PW];
	assign n_cnt  = meta_rd[COUNT_WIDTH-1:0];
	assign n_cnt_inc = (n_cnt == COUNT_MAX) ? n_cnt : n_cnt + 1'b1;
	// the head read stays on the ram output for the whole word end,
	// so a new node links to the old chain head
	assign meta_wd = cmd.ins_meta_wr
		? {len_q, head_rd, COUNT_WIDTH'(1)}
		: {n_len, n_next, n_cnt_inc};

	wfht_ram #(.WIDTH(MW), .DEPTH(POOL_NODES)) u_meta (
		.clk(clk),
		.wr_en(cmd.ins_meta_wr || cmd.upd_count),
		.wr_addr(cmd.ins_meta_wr ? used_q[NW-1:0] : ptr_q[NW-1:0]),
		.wr_data(meta_wd),
		.rd_en(cmd.node_rd),
		.rd_addr(ptr_q[NW-1:0]),
		.rd_data(meta_rd)
	);

	// node text, MAX_WORD_LEN bytes per node
	logic [7:0] text_rd;
	logic [TW-1:0] text_base_rd, text_base_wr;
	assign text_base_rd = TW'(ptr_q[NW-1:0] * MAX_WORD_LEN) + TW'(idx_q);
	assign text_base_wr = TW'(used_q[NW-1:0] * MAX_WORD_LEN) + TW'(idx_q);

	wfht_ram #(.WIDTH(8), .DEPTH(TD)) u_text (
		.clk(clk),
		.wr_en(cmd.ins_text_wr),
		.wr_addr(text_base_wr),
		.wr_data(word_q[idx_q[IW-1:0]]),
		.rd_en(cmd.text_rd),
		.rd_addr(text_base_rd),
		.rd_data(text_rd)
	);

	logic [7:0] cmp_byte_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= NIL;
			idx_q <= '0;
		end else begin
			if (cmd.take_head) begin
				ptr_q <= head_rd;
			end else if (cmd.follow_next) begin
				ptr_q <= n_next;
			end else if (cmd.head_wr) begin
				ptr_q <= used_q;
			end
			if (cmd.cmp_start) begin
				idx_q <= '0;
			end else if (cmd.cmp_step || cmd.ins_text_wr) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.text_rd) begin
			cmp_byte_q <= word_q[idx_q[IW-1:0]];
		end
	end

	assign stat.is_sep = char_code == wfht_pkg::CHAR_SPACE
		|| char_code == wfht_pkg::CHAR_PERIOD || char_code == wfht_pkg::CHAR_NEWLINE;
	assign stat.word_empty = len_q == '0;
	assign stat.ptr_valid  = ptr_q < used_q;
	assign stat.len_match  = n_len == len_q;
	assign stat.byte_match = text_rd == cmp_byte_q;
	assign stat.cmp_last   = idx_q == len_q;
	assign stat.ins_last   = idx_q == len_q;
	assign stat.pool_full  = used_q == NIL;
	assign stat.clr_last   = clr_q == BW'(BUCKETS - 1);

	assign res_bucket    = 8'(bkt);
	assign res_count     = 16'(n_cnt_inc);
	assign res_truncated = trunc_q;
endmodule

>>> design/wfht_ctrl.sv
// sequencer for word entry, chain walk, update and insertion
module wfht_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	input  wfht_pkg::wfht_status_t  stat,
	output wfht_pkg::wfht_cmd_t     cmd,
	output logic                    res_hit,
	output logic                    res_full
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_HEAD, S_HEAD_WAIT, S_META, S_CHECK, S_TEXT, S_TEXT_CHK,
		S_INSERT, S_INS_META, S_DONE
	} state_t;

	state_t state_q;
	logic   hit_q, full_q;

	assign in_ready  = state_q == S_IDLE && !out_valid;
	assign res_hit   = hit_q;
	assign res_full  = full_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_CLEAR: cmd.clr_wr = 1'b1;
			S_IDLE: begin
				if (in_valid && in_ready) begin
					if (!stat.is_sep) begin
						cmd.accept_char = 1'b1;
					end else if (stat.word_empty) begin
						cmd.clear_word = 1'b1;
					end else begin
						cmd.head_rd = 1'b1;
					end
				end
			end
			S_HEAD_WAIT: cmd.take_head = 1'b1;
			S_HEAD: begin
				cmd.node_rd   = 1'b1;
				cmd.cmp_start = 1'b1;
			end
			S_META: ;
			S_CHECK: begin
				if (stat.len_match && !stat.cmp_last) begin
					cmd.text_rd = 1'b1;
				end else if (!stat.len_match) begin
					cmd.follow_next = 1'b1;
				end else begin
					cmd.upd_count = 1'b1;
				end
			end
			S_TEXT: ;
			S_TEXT_CHK: begin
				if (!stat.byte_match) begin
					cmd.follow_next = 1'b1;
				end else begin
					cmd.cmp_step = 1'b1;
				end
			end
			S_INSERT: begin
				if (!stat.ins_last) begin
					cmd.ins_text_wr = 1'b1;
				end
			end
			S_INS_META: begin
				cmd.ins_meta_wr = 1'b1;
				cmd.head_wr     = 1'b1;
				cmd.alloc       = 1'b1;
			end
			S_DONE: begin
				if (out_ready) begin
					cmd.clear_word = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			out_valid <= 1'b0;
			hit_q     <= 1'b0;
			full_q    <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: if (stat.clr_last) state_q <= S_IDLE;
				S_IDLE: begin
					if (in_valid && in_ready && stat.is_sep && !stat.word_empty) begin
						state_q <= S_HEAD_WAIT;
					end
				end
				S_HEAD_WAIT: state_q <= S_HEAD;
				S_HEAD: begin
					// pointer now holds the chain head or the next node of the chain
					if (!stat.ptr_valid) begin
						if (stat.pool_full) begin
							hit_q     <= 1'b0;
							full_q    <= 1'b1;
							out_valid <= 1'b1;
							state_q   <= S_DONE;
						end else begin
							state_q <= S_INSERT;
						end
					end else begin
						state_q <= S_META;
					end
				end
				S_META: state_q <= S_CHECK;
				S_CHECK: begin
					if (stat.len_match && !stat.cmp_last) begin
						state_q <= S_TEXT;
					end else if (!stat.len_match) begin
						state_q <= S_HEAD;
					end else begin
						hit_q     <= 1'b1;
						full_q    <= 1'b0;
						out_valid <= 1'b1;
						state_q   <= S_DONE;
					end
				end
				S_TEXT: state_q <= S_TEXT_CHK;
				S_TEXT_CHK: begin
					if (!stat.byte_match) begin
						state_q <= S_HEAD;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_INSERT: if (stat.ins_last) state_q <= S_INS_META;
				S_INS_META: begin
					hit_q     <= 1'b0;
					full_q    <= 1'b0;
					out_valid <= 1'b1;
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> design/word_frequency_hash_table.sv
// top level of the word frequency hash table
//
// in_ch carries one text byte per beat in data[7:0]. space, period and
// newline end a word; other bytes are folded to lower case and collected,
// at most MAX_WORD_LEN of them, while the hash runs along.
// out_ch carries one result per non-empty word: {bucket, count, is_new,
// status} packed as data[26:19] bucket, data[18:3] count, data[2] is_new,
// data[1:0] status.
// a word end reads the bucket head, then walks the chain: each node goes
// through S_HEAD, S_META and S_CHECK for the length check, each compared
// byte through S_TEXT and S_TEXT_CHK, and a pointer past the used nodes
// ends the chain; a new word, unless the pool is full, stores its bytes
// in S_INSERT and closes the node record in S_INS_META; the result is
// held until taken. throughput thus depends on chain and word length.
// after reset a clearing pass writes every bucket head empty;
// no byte is taken during it.
// while a result stalls on out_ch, no new byte is taken.
module word_frequency_hash_table #(
	parameter int BUCKETS      = 256,
	parameter int MAX_WORD_LEN = 19,
	parameter int POOL_NODES   = 1024,
	parameter int COUNT_WIDTH  = 16
) (
	input logic         clk,
	input logic         arst_n,
	wfht_stream_if.sink   in_ch,
	wfht_stream_if.source out_ch
);
	wfht_pkg::wfht_cmd_t    cmd;
	wfht_pkg::wfht_status_t stat;
	logic [7:0]  res_bucket;
	logic [15:0] res_count;
	logic        res_truncated;
	logic        res_hit;
	logic        res_full;
	logic [1:0]  status;

	wfht_datapath #(
		.BUCKETS(BUCKETS), .MAX_WORD_LEN(MAX_WORD_LEN),
		.POOL_NODES(POOL_NODES), .COUNT_WIDTH(COUNT_WIDTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .char_code(in_ch.data[7:0]),
		.cmd(cmd), .stat(stat), .res_bucket(res_bucket),
		.res_count(res_count), .res_truncated(res_truncated)
	);

	wfht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat(stat), .cmd(cmd), .res_hit(res_hit), .res_full(res_full)
	);

	// pool full wins over truncation
	assign status = res_full ? wfht_pkg::STATUS_POOL_FULL
		: (res_truncated ? wfht_pkg::STATUS_TRUNCATED : wfht_pkg::STATUS_OK);

	// node record is still on the ram output after a hit;
	// an insert reports count one
	assign out_ch.data = {res_bucket,
		res_full ? 16'd0 : (res_hit ? res_count : 16'd1),
		!res_hit && !res_full, status};
endmodule
